FILE: src/cdrb_pkg.sv
// Shared types and codes for the circular deque ring buffer.
package cdrb_pkg;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] data_in;
    } t_req;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [4:0]  count;
    } t_rsp;

    // Side information for the result that leaves in the cycle after the request.
    typedef struct packed {
        logic       valid;
        logic       rd;
        logic [1:0] status;
        logic [4:0] count;
    } t_rsp_ctl;

endpackage

FILE: src/cdrb_ram.sv
// Ring store: one write port and one registered read port.
module cdrb_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cdrb_ctrl.sv
// Pointer, fill count and status logic that drives the ring store.
module cdrb_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_req_type,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic                o_re,
    output logic [AW-1:0]       o_raddr,
    output cdrb_pkg::t_rsp_ctl  o_rsp_ctl
);

    localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    cdrb_pkg::t_rsp_ctl r_rsp_ctl;

    logic [AW-1:0] w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic          w_empty, w_full, w_rd;
    logic [1:0]    w_status;
    logic [CW+4:0] w_count_ext;

    assign w_head_inc = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign w_head_dec = (r_head == '0) ? PTR_LAST : r_head - 1'b1;
    assign w_tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
    assign w_tail_dec = (r_tail == '0) ? PTR_LAST : r_tail - 1'b1;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_FULL);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        o_we     = 1'b0;
        o_waddr  = r_head;
        o_re     = 1'b0;
        o_raddr  = r_head;
        w_rd     = 1'b0;
        w_status = cdrb_pkg::ST_OK;
        case (i_req_type)
            cdrb_pkg::REQ_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = cdrb_pkg::ST_FULL;
                end else begin
                    n_head  = w_head_dec;
                    o_we    = i_accept;
                    o_waddr = w_head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            cdrb_pkg::REQ_PUSH_BACK: begin
                if (w_full) begin
                    w_status = cdrb_pkg::ST_FULL;
                end else begin
                    n_tail  = w_tail_inc;
                    o_we    = i_accept;
                    o_waddr = w_tail_inc;
                    n_count = r_count + 1'b1;
                end
            end
            cdrb_pkg::REQ_POP_FRONT, cdrb_pkg::REQ_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = cdrb_pkg::ST_EMPTY;
                end else begin
                    o_re    = i_accept;
                    o_raddr = r_head;
                    w_rd    = 1'b1;
                    if (i_req_type == cdrb_pkg::REQ_POP_FRONT) begin
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            cdrb_pkg::REQ_POP_BACK, cdrb_pkg::REQ_PEEK_BACK: begin
                if (w_empty) begin
                    w_status = cdrb_pkg::ST_EMPTY;
                end else begin
                    o_re    = i_accept;
                    o_raddr = r_tail;
                    w_rd    = 1'b1;
                    if (i_req_type == cdrb_pkg::REQ_POP_BACK) begin
                        n_tail  = w_tail_dec;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The result field is five bits wide whatever the depth.
    assign w_count_ext = {5'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head          <= '0;
            r_tail          <= PTR_LAST;
            r_count         <= '0;
            r_rsp_ctl.valid <= 1'b0;
        end else begin
            r_rsp_ctl.valid <= i_accept;
            if (i_accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_count <= n_count;
            end
        end
        r_rsp_ctl.rd     <= w_rd;
        r_rsp_ctl.status <= w_status;
        r_rsp_ctl.count  <= w_count_ext[4:0];
    end

    assign o_rsp_ctl = r_rsp_ctl;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fill count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (w_tail_inc == r_head))
        else $error("empty deque with inconsistent pointers");

    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("read and write issued for one item");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_rsp_ctl.valid)
        else $error("accepted item produced no result");

    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_ctl.valid && r_rsp_ctl.status == cdrb_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with stored items");

endmodule

FILE: src/circular_deque_ring_buffer.sv
// Top level of the circular deque ring buffer.
//
// Requests arrive on i_req (request code and push value) and are taken at
// each rising edge where start is high and busy is low. Each item pushes at
// the front or back, pops from either end or peeks either end of a deque of
// DEPTH entries of DATA_WIDTH bits held in one synchronous ring memory.
// Every item gives exactly one result on o_rsp, marked by o_valid for one
// cycle, in the cycle after the item is taken: the value read (zero for pushes
// and refused requests), a status (ok, full, empty) and the count after it.
// A new item may be taken in every cycle: an item either writes or reads one
// memory entry at its accept edge, and the registered read port returns the
// data for the result in the next cycle, so a write is always complete
// before a later item reads that entry. busy is high only while reset is
// held. Reset leaves the deque empty; the memory itself is not cleared and
// no pass over it is needed. The receiver cannot stall, and none is needed.
module circular_deque_ring_buffer #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cdrb_pkg::t_req   i_req,
    output logic             o_valid,
    output cdrb_pkg::t_rsp   o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                  w_accept;
    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH+31:0] w_wdata_ext;
    logic [DATA_WIDTH+31:0] w_rdata_ext;
    cdrb_pkg::t_rsp_ctl    w_rsp_ctl;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    assign w_wdata_ext = {{DATA_WIDTH{1'b0}}, i_req.data_in};
    assign w_wdata     = w_wdata_ext[DATA_WIDTH-1:0];

    cdrb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req.req_type),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .o_rsp_ctl  (w_rsp_ctl)
    );

    cdrb_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rdata_ext = {32'b0, w_rdata};

    assign o_valid        = w_rsp_ctl.valid;
    assign o_rsp.data_out = w_rsp_ctl.rd ? w_rdata_ext[31:0] : 32'b0;
    assign o_rsp.status   = w_rsp_ctl.status;
    assign o_rsp.count    = w_rsp_ctl.count;

endmodule

FILE: test/tb_circular_deque_ring_buffer.sv
// Self-checking testbench for the circular deque ring buffer: directed table, then random traffic.
module tb_circular_deque_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RING_DEPTH   = 16;
    localparam int         PHASE_ITEMS  = 412;
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        cdrb_pkg::t_req req;
        logic [4:0]     reps;
        logic           typed;
        cdrb_pkg::t_rsp want;
    } t_stim_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    cdrb_pkg::t_req i_req = '0;
    logic           o_valid;
    cdrb_pkg::t_rsp o_rsp;

    // Typed-in expectation that travels alongside the item being offered.
    logic           typed_valid = 1'b0;
    cdrb_pkg::t_rsp typed_rsp = '0;

    int     idle_pct = 0;
    int     errors = 0;

    logic [31:0]    deque_mem [RING_DEPTH];
    logic [3:0]     front_ptr;
    logic [3:0]     back_ptr;
    logic [4:0]     stored;
    cdrb_pkg::t_rsp pending_rsp [$];
    t_stim_row      stim_table [$];

    circular_deque_ring_buffer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Applies one request to the local copy of the deque and returns its result.
    function automatic cdrb_pkg::t_rsp deque_step(input cdrb_pkg::t_req r);
        cdrb_pkg::t_rsp res;
        logic is_empty;
        logic is_full;
        res = '0;
        res.status = cdrb_pkg::ST_OK;
        is_empty = (stored == 5'd0);
        is_full = (stored == 5'(RING_DEPTH));
        case (r.req_type)
            cdrb_pkg::REQ_PUSH_FRONT, cdrb_pkg::REQ_PUSH_BACK: begin
                if (is_full) begin
                    res.status = cdrb_pkg::ST_FULL;
                end else if (r.req_type == cdrb_pkg::REQ_PUSH_FRONT) begin
                    front_ptr = front_ptr - 4'd1;
                    deque_mem[front_ptr] = r.data_in;
                    stored++;
                end else begin
                    back_ptr = back_ptr + 4'd1;
                    deque_mem[back_ptr] = r.data_in;
                    stored++;
                end
            end
            cdrb_pkg::REQ_POP_FRONT, cdrb_pkg::REQ_POP_BACK,
            cdrb_pkg::REQ_PEEK_FRONT, cdrb_pkg::REQ_PEEK_BACK: begin
                if (is_empty) begin
                    res.status = cdrb_pkg::ST_EMPTY;
                end else begin
                    if (r.req_type == cdrb_pkg::REQ_POP_FRONT ||
                        r.req_type == cdrb_pkg::REQ_PEEK_FRONT)
                        res.data_out = deque_mem[front_ptr];
                    else
                        res.data_out = deque_mem[back_ptr];
                    if (r.req_type == cdrb_pkg::REQ_POP_FRONT) begin
                        front_ptr = front_ptr + 4'd1;
                        stored--;
                    end else if (r.req_type == cdrb_pkg::REQ_POP_BACK) begin
                        back_ptr = back_ptr - 4'd1;
                        stored--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = stored;
        return res;
    endfunction

    // Results are checked and accepted items predicted on the same edge.
    always @(posedge i_clk) begin
        cdrb_pkg::t_rsp want;
        if (!i_rst_n) begin
            front_ptr <= 4'd0;
            back_ptr <= 4'(RING_DEPTH - 1);
            stored <= 5'd0;
            pending_rsp.delete();
        end else begin
            if (o_valid) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("result strobe with no item outstanding");
                end else begin
                    want = pending_rsp.pop_front();
                    check_field("data_out", o_rsp.data_out, want.data_out);
                    check_field("status", 32'(o_rsp.status), 32'(want.status));
                    check_field("count", 32'(o_rsp.count), 32'(want.count));
                end
            end
            if (start && !busy) begin
                want = deque_step(i_req);
                if (typed_valid)
                    want = typed_rsp;
                pending_rsp.push_back(want);
            end
        end
    end

    task automatic send_item(input cdrb_pkg::t_req r, input logic typed,
                             input cdrb_pkg::t_rsp want);
        start <= 1'b1;
        i_req <= r;
        typed_valid <= typed;
        typed_rsp <= want;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [2:0] code, input logic [31:0] data,
                           input int reps, input logic typed, input logic [31:0] dout,
                           input logic [1:0] st, input logic [4:0] cnt);
        t_stim_row row;
        row.req = '{req_type: code, data_in: data};
        row.reps = 5'(reps);
        row.typed = typed;
        row.want = '{data_out: dout, status: st, count: cnt};
        stim_table.push_back(row);
    endtask

    function automatic cdrb_pkg::t_req random_req(input int push_pct);
        cdrb_pkg::t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.req_type = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
        else if (pick < 3 + push_pct)
            r.req_type = $urandom_range(0, 1) ? cdrb_pkg::REQ_PUSH_BACK
                                              : cdrb_pkg::REQ_PUSH_FRONT;
        else if ($urandom_range(0, 3) != 0)
            r.req_type = $urandom_range(0, 1) ? cdrb_pkg::REQ_POP_BACK
                                              : cdrb_pkg::REQ_POP_FRONT;
        else
            r.req_type = $urandom_range(0, 1) ? cdrb_pkg::REQ_PEEK_BACK
                                              : cdrb_pkg::REQ_PEEK_FRONT;
        case ($urandom_range(0, 15))
            0:       r.data_in = 32'h0;
            1:       r.data_in = 32'hFFFF_FFFF;
            default: r.data_in = $urandom;
        endcase
        return r;
    endfunction

    initial begin
        int         push_mix [5];
        int         phase_idle [4];
        int         guard;
        t_stim_row  row;
        push_mix = '{75, 30, 50, 92, 8};
        phase_idle = '{0, 69, 0, 7};

        // request, data, reps, typed, data_out, status, count
        add_row(cdrb_pkg::REQ_POP_FRONT, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_EMPTY, 5'd0);
        add_row(cdrb_pkg::REQ_POP_BACK, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_EMPTY, 5'd0);
        add_row(cdrb_pkg::REQ_PEEK_FRONT, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_EMPTY, 5'd0);
        add_row(cdrb_pkg::REQ_PEEK_BACK, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_EMPTY, 5'd0);
        add_row(REQ_UNUSED_6, 32'hFFFF_FFFF, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(REQ_UNUSED_7, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd1);
        add_row(cdrb_pkg::REQ_PEEK_FRONT, 32'h0, 1, 1, 32'hFFFF_FFFF, cdrb_pkg::ST_OK, 5'd1);
        add_row(cdrb_pkg::REQ_PEEK_BACK, 32'h0, 1, 1, 32'hFFFF_FFFF, cdrb_pkg::ST_OK, 5'd1);
        add_row(cdrb_pkg::REQ_PUSH_FRONT, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd2);
        add_row(cdrb_pkg::REQ_PEEK_FRONT, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd2);
        add_row(cdrb_pkg::REQ_POP_BACK, 32'h0, 1, 1, 32'hFFFF_FFFF, cdrb_pkg::ST_OK, 5'd1);
        add_row(cdrb_pkg::REQ_POP_FRONT, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_PUSH_FRONT, 32'h1000_0000, 8, 0, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_PUSH_BACK, 32'h2000_0000, 8, 0, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_PUSH_BACK, 32'hDEAD_BEEF, 1, 1, 32'h0, cdrb_pkg::ST_FULL, 5'd16);
        add_row(cdrb_pkg::REQ_PUSH_FRONT, 32'h5555_AAAA, 1, 1, 32'h0, cdrb_pkg::ST_FULL, 5'd16);
        add_row(REQ_UNUSED_7, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_OK, 5'd16);
        add_row(cdrb_pkg::REQ_PEEK_BACK, 32'h0, 1, 0, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_POP_BACK, 32'h0, 9, 0, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_POP_FRONT, 32'h0, 7, 0, 32'h0, cdrb_pkg::ST_OK, 5'd0);
        add_row(cdrb_pkg::REQ_POP_FRONT, 32'h0, 1, 1, 32'h0, cdrb_pkg::ST_EMPTY, 5'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            for (int k = 0; k < row.reps; k++)
                send_item('{req_type: row.req.req_type, data_in: row.req.data_in + k},
                          row.typed, row.want);
        end

        // Push pressure swings every fifty items so the deque drifts between full and empty.
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_req(push_mix[(n / 50) % 5]), 1'b0, '0);
        end
        start <= 1'b0;

        guard = 0;
        while (pending_rsp.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_rsp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));

        if (errors == 0)
            $display("** circular_deque_ring_buffer: PASSED **");
        else
            $display("** circular_deque_ring_buffer: FAILED **");
        $finish;
    end

    initial begin
        #2ms;
        $display("** circular_deque_ring_buffer: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/cdrb_pkg.sv
src/cdrb_ram.sv
src/cdrb_ctrl.sv
src/circular_deque_ring_buffer.sv
test/tb_circular_deque_ring_buffer.sv
